FILE: rtl/r2sp_pkg.sv
// Shared types and constants for the RESP2 stream parser.
package r2sp_pkg;

   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int NUM_W     = 32;
   localparam int LIMIT_W   = 31;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_BULK  = 8'h24;
   localparam logic [BYTE_W-1:0] CH_ARRAY = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam logic [NUM_W-1:0] NEG_LIMIT = 32'h8000_0000;

   localparam logic [LIMIT_W-1:0] MAX_BULK_RESET  = 31'd536870912;
   localparam logic [LIMIT_W-1:0] MAX_ARRAY_RESET = 31'd1048576;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BULK  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ARRAY = 4'd1;

   localparam logic [KIND_W-1:0] KIND_SIMPLE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTEGER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BULK    = 2'd3;

   typedef enum logic [8:0] {
      PH_IDLE      = 9'b000000001,
      PH_LINE      = 9'b000000010,
      PH_NUM_B     = 9'b000000100,
      PH_NUM_B_LF  = 9'b000001000,
      PH_BULK_DATA = 9'b000010000,
      PH_BULK_CR   = 9'b000100000,
      PH_BULK_LF   = 9'b001000000,
      PH_NUM_A     = 9'b010000000,
      PH_NUM_A_LF  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic finish;
   } stack_cmd_type;

   typedef struct packed {
      logic full;
      logic msg_done;
   } stack_stat_type;

endpackage

FILE: rtl/r2sp_if.sv
// Handshake channel interfaces for request bytes, results and register writes.
interface r2sp_req_if import r2sp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface r2sp_rsp_if import r2sp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] value_byte;
   logic              content_valid;
   logic              cr_before;
   logic              value_done;
   logic [KIND_W-1:0] value_kind;
   logic              message_done;
   logic              syntax_error;

   modport source (output valid, output value_byte, output content_valid,
                   output cr_before, output value_done, output value_kind,
                   output message_done, output syntax_error, input ready);
   modport sink   (input valid, input value_byte, input content_valid,
                   input cr_before, input value_done, input value_kind,
                   input message_done, input syntax_error, output ready);
endinterface

interface r2sp_csr_if import r2sp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/resp2_stream_parser.sv
// RESP2 request stream parser: one byte in, one result out.
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register sets the pace, and
// a new byte is taken whenever that register is empty or being drained.
// Reset: synchronous; parser returns to expecting a type prefix, the nesting
// stack is emptied and the length/count limits return to their defaults.
module resp2_stream_parser import r2sp_pkg::*; #(
   parameter int MAX_DEPTH = 8
) (
   input  logic   clock,
   input  logic   reset,
   r2sp_req_if.sink   req_ch,
   r2sp_rsp_if.source rsp_ch,
   r2sp_csr_if.sink   csr_ch
);

   // configuration
   logic [LIMIT_W-1:0] max_bulk_ff;
   logic [LIMIT_W-1:0] max_array_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [KIND_W-1:0]  line_kind_ff, line_kind_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               digit_seen_ff, digit_seen_in;
   logic [LIMIT_W-1:0] bulk_rem_ff, bulk_rem_in;
   logic               cr_pend_ff, cr_pend_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] value_byte_ff;
   logic              content_valid_ff;
   logic              cr_before_ff;
   logic              value_done_ff;
   logic [KIND_W-1:0] value_kind_ff;
   logic              message_done_ff;
   logic              syntax_error_ff;

   logic [BYTE_W-1:0] o_byte;
   logic              o_valid;
   logic              o_crb;
   logic              o_done;
   logic [KIND_W-1:0] o_kind;
   logic              o_mdone;
   logic              err;
   logic              do_push;
   logic              do_finish;

   logic                accept;
   logic [BYTE_W-1:0]   b;
   logic                is_digit;
   logic [NUM_W+3:0]    acc_x10;
   logic [NUM_W-1:0]    acc_sat;
   logic [LIMIT_W-1:0]  bulk_dec;

   stack_cmd_type  stk_cmd;
   stack_stat_type stk_stat;

   assign b            = req_ch.in_byte;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign acc_x10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + (NUM_W+4)'(b - CH_ZERO);
   assign acc_sat  = (acc_x10[NUM_W+3:NUM_W] != '0) ? '1 : acc_x10[NUM_W-1:0];
   assign bulk_dec = bulk_rem_ff - LIMIT_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      line_kind_in  = line_kind_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      digit_seen_in = digit_seen_ff;
      bulk_rem_in   = bulk_rem_ff;
      cr_pend_in    = cr_pend_ff;
      o_byte        = '0;
      o_valid       = 1'b0;
      o_crb         = 1'b0;
      o_done        = 1'b0;
      o_kind        = KIND_SIMPLE;
      o_mdone       = 1'b0;
      err           = 1'b0;
      do_push       = 1'b0;
      do_finish     = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (b == CH_PLUS) begin
               line_kind_in = KIND_SIMPLE;
               phase_in     = PH_LINE;
            end else if (b == CH_MINUS) begin
               line_kind_in = KIND_ERROR;
               phase_in     = PH_LINE;
            end else if (b == CH_COLON) begin
               line_kind_in = KIND_INTEGER;
               phase_in     = PH_LINE;
            end else if (b == CH_BULK) begin
               acc_in        = '0;
               neg_in        = 1'b0;
               digit_seen_in = 1'b0;
               phase_in      = PH_NUM_B;
            end else if (b == CH_ARRAY) begin
               acc_in        = '0;
               neg_in        = 1'b0;
               digit_seen_in = 1'b0;
               phase_in      = PH_NUM_A;
            end else begin
               err = 1'b1;
            end
         end
         PH_LINE: begin
            if (cr_pend_ff) begin
               if (b == CH_LF) begin
                  cr_pend_in = 1'b0;
                  o_done     = 1'b1;
                  o_kind     = line_kind_ff;
                  do_finish  = 1'b1;
                  o_mdone    = stk_stat.msg_done;
                  phase_in   = PH_IDLE;
               end else if (b == CH_CR) begin
                  // earlier CR goes out as content, the new one is held back
                  o_byte  = CH_CR;
                  o_valid = 1'b1;
                  o_kind  = line_kind_ff;
               end else begin
                  o_byte     = b;
                  o_valid    = 1'b1;
                  o_crb      = 1'b1;
                  o_kind     = line_kind_ff;
                  cr_pend_in = 1'b0;
               end
            end else if (b == CH_CR) begin
               cr_pend_in = 1'b1;
            end else begin
               o_byte  = b;
               o_valid = 1'b1;
               o_kind  = line_kind_ff;
            end
         end
         PH_NUM_B, PH_NUM_A: begin
            if (is_digit) begin
               acc_in        = acc_sat;
               digit_seen_in = 1'b1;
            end else if (b == CH_MINUS && !digit_seen_ff && !neg_ff) begin
               neg_in = 1'b1;
            end else if (b == CH_CR && digit_seen_ff) begin
               phase_in = (phase_ff == PH_NUM_B) ? PH_NUM_B_LF : PH_NUM_A_LF;
            end else begin
               err = 1'b1;
            end
         end
         PH_NUM_B_LF: begin
            if (b != CH_LF) begin
               err = 1'b1;
            end else if (neg_ff) begin
               // null bulk string: done here, no trailer
               if (acc_ff > NEG_LIMIT) begin
                  err = 1'b1;
               end else begin
                  o_done        = 1'b1;
                  o_kind        = KIND_BULK;
                  do_finish     = 1'b1;
                  o_mdone       = stk_stat.msg_done;
                  phase_in      = PH_IDLE;
                  acc_in        = '0;
                  neg_in        = 1'b0;
                  digit_seen_in = 1'b0;
               end
            end else if (acc_ff > {1'b0, max_bulk_ff}) begin
               err = 1'b1;
            end else begin
               bulk_rem_in   = acc_ff[LIMIT_W-1:0];
               phase_in      = (acc_ff != '0) ? PH_BULK_DATA : PH_BULK_CR;
               acc_in        = '0;
               neg_in        = 1'b0;
               digit_seen_in = 1'b0;
            end
         end
         PH_NUM_A_LF: begin
            if (b != CH_LF) begin
               err = 1'b1;
            end else if (neg_ff || acc_ff == '0) begin
               // null or empty array
               if (neg_ff && acc_ff > NEG_LIMIT) begin
                  err = 1'b1;
               end else begin
                  do_finish     = 1'b1;
                  o_mdone       = stk_stat.msg_done;
                  phase_in      = PH_IDLE;
                  acc_in        = '0;
                  neg_in        = 1'b0;
                  digit_seen_in = 1'b0;
               end
            end else if (acc_ff > {1'b0, max_array_ff} || stk_stat.full) begin
               err = 1'b1;
            end else begin
               do_push       = 1'b1;
               phase_in      = PH_IDLE;
               acc_in        = '0;
               neg_in        = 1'b0;
               digit_seen_in = 1'b0;
            end
         end
         PH_BULK_DATA: begin
            o_byte  = b;
            o_valid = 1'b1;
            o_kind  = KIND_BULK;
            if (bulk_rem_ff != '0) begin
               bulk_rem_in = bulk_dec;
               if (bulk_dec == '0) begin
                  phase_in = PH_BULK_CR;
               end
            end else begin
               phase_in = PH_BULK_CR;
            end
         end
         PH_BULK_CR: begin
            if (b == CH_CR) begin
               phase_in = PH_BULK_LF;
            end else begin
               err = 1'b1;
            end
         end
         PH_BULK_LF: begin
            if (b == CH_LF) begin
               o_done    = 1'b1;
               o_kind    = KIND_BULK;
               do_finish = 1'b1;
               o_mdone   = stk_stat.msg_done;
               phase_in  = PH_IDLE;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase

      if (err) begin
         phase_in      = PH_IDLE;
         line_kind_in  = KIND_SIMPLE;
         acc_in        = '0;
         neg_in        = 1'b0;
         digit_seen_in = 1'b0;
         bulk_rem_in   = '0;
         cr_pend_in    = 1'b0;
         o_byte        = '0;
         o_valid       = 1'b0;
         o_crb         = 1'b0;
         o_done        = 1'b0;
         o_kind        = KIND_SIMPLE;
         o_mdone       = 1'b0;
         do_push       = 1'b0;
         do_finish     = 1'b0;
      end
   end

   assign stk_cmd.clear  = accept && err;
   assign stk_cmd.push   = accept && do_push;
   assign stk_cmd.finish = accept && do_finish;

   r2sp_nest_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stk_cmd),
      .push_count (acc_ff),
      .stat       (stk_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bulk_ff  <= MAX_BULK_RESET;
         max_array_ff <= MAX_ARRAY_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         if (csr_ch.index == CSR_MAX_BULK) begin
            max_bulk_ff <= csr_ch.data[LIMIT_W-1:0];
         end else if (csr_ch.index == CSR_MAX_ARRAY) begin
            max_array_ff <= csr_ch.data[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         line_kind_ff  <= KIND_SIMPLE;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         digit_seen_ff <= 1'b0;
         bulk_rem_ff   <= '0;
         cr_pend_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         line_kind_ff  <= line_kind_in;
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
         digit_seen_ff <= digit_seen_in;
         bulk_rem_ff   <= bulk_rem_in;
         cr_pend_ff    <= cr_pend_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_byte_ff    <= o_byte;
         content_valid_ff <= o_valid;
         cr_before_ff     <= o_crb;
         value_done_ff    <= o_done;
         value_kind_ff    <= o_kind;
         message_done_ff  <= o_mdone;
         syntax_error_ff  <= err;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.value_byte    = value_byte_ff;
   assign rsp_ch.content_valid = content_valid_ff;
   assign rsp_ch.cr_before     = cr_before_ff;
   assign rsp_ch.value_done    = value_done_ff;
   assign rsp_ch.value_kind    = value_kind_ff;
   assign rsp_ch.message_done  = message_done_ff;
   assign rsp_ch.syntax_error  = syntax_error_ff;

endmodule

FILE: rtl/r2sp_nest_stack.sv
// Stack of remaining array element counts; one completion unwinds every finished level at once.
module r2sp_nest_stack import r2sp_pkg::*; #(
   parameter int MAX_DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  stack_cmd_type    cmd,
   input  logic [NUM_W-1:0] push_count,
   output stack_stat_type   stat
);

   localparam int LVL_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [NUM_W-1:0]     count_ff [MAX_DEPTH];
   logic [MAX_DEPTH-1:0] one_ff;
   logic [LVL_W-1:0]     level_ff;
   logic [LVL_W-1:0]     level_in;

   logic [LVL_W-1:0] new_lvl;
   logic [LVL_W-1:0] new_lvl_m1;
   logic [IDX_W-1:0] dec_idx;
   logic [IDX_W-1:0] push_idx;
   logic [NUM_W-1:0] dec_val;

   // entries flagged as holding one element left pop together on completion
   always_comb begin
      new_lvl = level_ff;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
         if (one_ff[i] && new_lvl == LVL_W'(i + 1)) begin
            new_lvl = LVL_W'(i);
         end
      end
   end

   assign new_lvl_m1 = new_lvl - LVL_W'(1);
   assign dec_idx    = new_lvl_m1[IDX_W-1:0];
   assign push_idx   = level_ff[IDX_W-1:0];
   assign dec_val    = count_ff[dec_idx] - NUM_W'(1);

   assign stat.full     = (level_ff >= LVL_W'(MAX_DEPTH));
   assign stat.msg_done = (new_lvl == '0);

   always_comb begin
      level_in = level_ff;
      if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         level_in = level_ff + LVL_W'(1);
      end else if (cmd.finish) begin
         level_in = new_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!cmd.clear) begin
         if (cmd.push) begin
            count_ff[push_idx] <= push_count;
            one_ff[push_idx]   <= (push_count == NUM_W'(1));
         end else if (cmd.finish && new_lvl != '0) begin
            count_ff[dec_idx] <= dec_val;
            one_ff[dec_idx]   <= (dec_val == NUM_W'(1));
         end
      end
   end

endmodule
